// ----- rtl/kps_pkg.sv -----
package kps_pkg;

	localparam int unsigned MAP_W   = 16;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned CMD_W   = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX        = '1;
	localparam logic [COUNT_W-1:0] LONG_PRESS_RESET = COUNT_W'(30);

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK      = 2'd0,
		CMD_READ_KEY  = 2'd1,
		CMD_READ_LONG = 2'd2
	} cmd_t;

	// one accepted beat, columns already packed into the key map
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [MAP_W-1:0] key_map;
	} scan_item_t;

	typedef struct packed {
		logic [MAP_W-1:0] key_bits;
		logic             multi_key;
		logic             long_press;
		logic             keys_held;
	} result_t;

endpackage

// ----- rtl/kps_in_if.sv -----
interface kps_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [3:0] row1_cols;
	logic [3:0] row2_cols;
	logic [3:0] row3_cols;
	logic [3:0] row4_cols;

	modport source (output valid, cmd, row1_cols, row2_cols, row3_cols, row4_cols,
		input ready);
	modport sink (input valid, cmd, row1_cols, row2_cols, row3_cols, row4_cols,
		output ready);
endinterface

// ----- rtl/kps_out_if.sv -----
interface kps_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] key_bits;
	logic        multi_key;
	logic        long_press;
	logic        keys_held;

	modport source (output valid, key_bits, multi_key, long_press, keys_held,
		input ready);
	modport sink (input valid, key_bits, multi_key, long_press, keys_held,
		output ready);
endinterface

// ----- rtl/matrix_keypad_scanner_core.sv -----
// 4x4 keypad release detector.
// scan_in carries one command per beat: a scan tick with four row column
// samples, a read-and-clear of the released key, or a read-and-clear of the
// long-press flag. Every input beat yields exactly one result beat on
// result_out, in order.
// Timing: the input beat is registered in the input register, then its result
// in the result register, which drives result_out.valid. Throughput: one beat
// per cycle while result_out is not stalled; the key state is
// updated in the single logic stage between the two registers.
// cfg_wr_en/cfg_wr_data set the long-press threshold; write only while idle.
// Reset clears the key map, held state, hold counter, released key and
// long-press flag, and loads a threshold of 30 ticks.
// When the receiver stalls, the result register holds its beat, the input
// register holds one more, and scan_in.ready drops until result_out drains.
module matrix_keypad_scanner_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	kps_in_if.sink      scan_in,
	kps_out_if.source   result_out
);

	logic [kps_pkg::COUNT_W-1:0] long_press_ticks_q;
	kps_pkg::scan_item_t         item_s1;
	logic                        valid_s1;
	kps_pkg::result_t            res_comb;
	kps_pkg::result_t            res_q;
	logic                        out_valid_q;
	logic                        advance;

	assign advance       = valid_s1 && (!out_valid_q || result_out.ready);
	assign scan_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) long_press_ticks_q <= kps_pkg::LONG_PRESS_RESET;
		else if (cfg_wr_en) long_press_ticks_q <= cfg_wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan_in.ready) begin
			valid_s1 <= scan_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_in.valid && scan_in.ready) begin
			item_s1.cmd     <= scan_in.cmd;
			item_s1.key_map <= {scan_in.row4_cols, scan_in.row3_cols,
				scan_in.row2_cols, scan_in.row1_cols};
		end
	end

	kps_state u_state (
		.clk              (clk),
		.arst_n           (arst_n),
		.commit           (advance),
		.item             (item_s1),
		.long_press_ticks (long_press_ticks_q),
		.result           (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || result_out.ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= res_comb;
	end

	assign result_out.valid      = out_valid_q;
	assign result_out.key_bits   = res_q.key_bits;
	assign result_out.multi_key  = res_q.multi_key;
	assign result_out.long_press = res_q.long_press;
	assign result_out.keys_held  = res_q.keys_held;

endmodule

// ----- rtl/kps_state.sv -----
module kps_state (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 commit,
	input  kps_pkg::scan_item_t                  item,
	input  logic [kps_pkg::COUNT_W-1:0]          long_press_ticks,
	output kps_pkg::result_t                     result
);

	logic [kps_pkg::MAP_W-1:0]   key_map_q,      key_map_d;
	logic                        held_q,         held_d;
	logic [kps_pkg::COUNT_W-1:0] hold_count_q,   hold_count_d;
	logic [kps_pkg::MAP_W-1:0]   released_key_q, released_key_d;
	logic                        long_flag_q,    long_flag_d;
	logic                        rel_single;
	logic [kps_pkg::COUNT_W-1:0] count_inc;

	// exactly one bit set: nonzero and clearing the lowest set bit leaves zero
	assign rel_single = (released_key_q != '0) &&
		((released_key_q & (released_key_q - kps_pkg::MAP_W'(1))) == '0);

	assign count_inc = (held_q && hold_count_q != kps_pkg::COUNT_MAX) ?
		hold_count_q + kps_pkg::COUNT_W'(1) : hold_count_q;

	always_comb begin
		key_map_d         = key_map_q;
		held_d            = held_q;
		hold_count_d      = hold_count_q;
		released_key_d    = released_key_q;
		long_flag_d       = long_flag_q;
		result.key_bits   = '0;
		result.multi_key  = 1'b0;
		result.long_press = 1'b0;
		case (item.cmd)
			kps_pkg::CMD_TICK: begin
				key_map_d    = item.key_map;
				hold_count_d = count_inc;
				if (item.key_map != key_map_q) begin
					if (item.key_map == '0) begin
						held_d         = 1'b0;
						released_key_d = key_map_q;
						if (count_inc > long_press_ticks) long_flag_d = 1'b1;
						hold_count_d   = '0;
					end else begin
						held_d = 1'b1;
					end
				end
			end
			kps_pkg::CMD_READ_KEY: begin
				released_key_d = '0;
				if (rel_single) result.key_bits = released_key_q;
				else if (released_key_q != '0) result.multi_key = 1'b1;
			end
			kps_pkg::CMD_READ_LONG: begin
				result.long_press = long_flag_q;
				long_flag_d       = 1'b0;
			end
			default: ;
		endcase
		result.keys_held = held_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_map_q      <= '0;
			held_q         <= 1'b0;
			hold_count_q   <= '0;
			released_key_q <= '0;
			long_flag_q    <= 1'b0;
		end else if (commit) begin
			key_map_q      <= key_map_d;
			held_q         <= held_d;
			hold_count_q   <= hold_count_d;
			released_key_q <= released_key_d;
			long_flag_q    <= long_flag_d;
		end
	end

endmodule

// ----- bench/tb_matrix_keypad_scanner_core.sv -----
// Tracks the keypad state beat by beat and holds the results still to arrive.
class keypad_scoreboard;
	logic [kps_pkg::COUNT_W-1:0] threshold;
	logic [kps_pkg::MAP_W-1:0]   last_map;
	logic                        held;
	logic [kps_pkg::COUNT_W-1:0] hold_ticks;
	logic [kps_pkg::MAP_W-1:0]   latched_key;
	logic                        long_pending;
	kps_pkg::result_t            awaited_q[$];

	int unsigned mismatches;
	int unsigned checked;
	int unsigned long_hits;
	int unsigned multi_reads;
	int unsigned single_reads;

	function new();
		threshold    = kps_pkg::LONG_PRESS_RESET;
		last_map     = '0;
		held         = 1'b0;
		hold_ticks   = '0;
		latched_key  = '0;
		long_pending = 1'b0;
	endfunction

	function void note_beat(kps_pkg::scan_item_t beat);
		kps_pkg::result_t          want;
		logic [kps_pkg::MAP_W-1:0] prev;
		int unsigned               ones;
		want = '0;
		case (beat.cmd)
			kps_pkg::CMD_TICK: begin
				prev     = last_map;
				last_map = beat.key_map;
				// counts on the releasing tick too, since held is still set
				if (held && hold_ticks != kps_pkg::COUNT_MAX)
					hold_ticks++;
				if (beat.key_map != prev) begin
					if (beat.key_map == '0) begin
						held        = 1'b0;
						latched_key = prev;
						if (hold_ticks > threshold)
							long_pending = 1'b1;
						hold_ticks = '0;
					end else begin
						held = 1'b1;
					end
				end
			end
			kps_pkg::CMD_READ_KEY: begin
				ones        = $countones(latched_key);
				if (ones == 1) begin
					want.key_bits = latched_key;
					single_reads++;
				end else if (ones > 1) begin
					want.multi_key = 1'b1;
					multi_reads++;
				end
				latched_key = '0;
			end
			kps_pkg::CMD_READ_LONG: begin
				want.long_press = long_pending;
				if (long_pending)
					long_hits++;
				long_pending = 1'b0;
			end
			default: begin
			end
		endcase
		want.keys_held = held;
		awaited_q.push_back(want);
	endfunction

	function void flag_field(string field, int unsigned want, int unsigned seen);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch in %s, result %0d: expected 0x%0h, got 0x%0h",
				field, checked, want, seen);
	endfunction

	function void check_result(kps_pkg::result_t got);
		kps_pkg::result_t want;
		if (awaited_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result beat: key_bits 0x%0h multi %0b long %0b held %0b",
					got.key_bits, got.multi_key, got.long_press, got.keys_held);
			return;
		end
		want = awaited_q.pop_front();
		if (got.key_bits !== want.key_bits)
			flag_field("key_bits", want.key_bits, got.key_bits);
		if (got.multi_key !== want.multi_key)
			flag_field("multi_key", want.multi_key, got.multi_key);
		if (got.long_press !== want.long_press)
			flag_field("long_press", want.long_press, got.long_press);
		if (got.keys_held !== want.keys_held)
			flag_field("keys_held", want.keys_held, got.keys_held);
		checked++;
	endfunction

	function int unsigned failures();
		return mismatches + awaited_q.size();
	endfunction
endclass

module tb_matrix_keypad_scanner_core;
	localparam logic [kps_pkg::CMD_W-1:0] CMD_UNUSED     = 2'd3;
	localparam int unsigned               CYCLE_LIMIT    = 40000;
	localparam int unsigned               PHASE_ITEMS    = 190;
	localparam int unsigned               HOLDOFF_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;

	kps_in_if  scan_in ();
	kps_out_if result_out ();

	matrix_keypad_scanner_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.scan_in    (scan_in),
		.result_out (result_out)
	);

	keypad_scoreboard board = new();

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	bit          hold_off       = 1'b0;
	int unsigned sent           = 0;
	int unsigned cycles         = 0;

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, board.awaited_q.size());
			$display("status: fail");
			$finish;
		end
	end

	// result side: random stalls, plus a long hold-off when requested
	initial begin
		kps_pkg::result_t got;
		forever begin
			result_out.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
			@(posedge clk);
			if (arst_n && result_out.valid && result_out.ready) begin
				got.key_bits   = result_out.key_bits;
				got.multi_key  = result_out.multi_key;
				got.long_press = result_out.long_press;
				got.keys_held  = result_out.keys_held;
				board.check_result(got);
			end
		end
	end

	task automatic send_beat(input logic [kps_pkg::CMD_W-1:0] op,
		input logic [kps_pkg::MAP_W-1:0] map);
		kps_pkg::scan_item_t beat;
		beat.cmd     = op;
		beat.key_map = map;
		while ($urandom_range(99) < send_idle_pct) begin
			scan_in.valid <= 1'b0;
			@(posedge clk);
		end
		scan_in.valid     <= 1'b1;
		scan_in.cmd       <= op;
		scan_in.row1_cols <= map[3:0];
		scan_in.row2_cols <= map[7:4];
		scan_in.row3_cols <= map[11:8];
		scan_in.row4_cols <= map[15:12];
		@(posedge clk);
		while (!scan_in.ready)
			@(posedge clk);
		board.note_beat(beat);
		sent++;
	endtask

	task automatic hold_map(input logic [kps_pkg::MAP_W-1:0] map, input int unsigned ticks);
		repeat (ticks)
			send_beat(kps_pkg::CMD_TICK, map);
	endtask

	task automatic drain();
		scan_in.valid <= 1'b0;
		while (board.awaited_q.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic write_threshold(input logic [kps_pkg::COUNT_W-1:0] value);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.threshold = value;
	endtask

	function automatic logic [kps_pkg::MAP_W-1:0] pick_map();
		logic [kps_pkg::MAP_W-1:0] map;
		case ($urandom_range(2))
			0: map = kps_pkg::MAP_W'(1) << $urandom_range(kps_pkg::MAP_W - 1);
			1: map = kps_pkg::MAP_W'($urandom_range(15, 1)) << (4 * $urandom_range(3));
			default: begin
				do
					map = kps_pkg::MAP_W'($urandom);
				while (map == '0);
			end
		endcase
		return map;
	endfunction

	// press, optional slide to another nonzero map, release, then reads
	task automatic press_release();
		logic [kps_pkg::MAP_W-1:0] map;
		map = pick_map();
		hold_map(map, $urandom_range(13, 1));
		if ($urandom_range(3) == 0)
			hold_map(pick_map(), $urandom_range(4, 1));
		hold_map('0, $urandom_range(2, 1));
		if ($urandom_range(3) != 0)
			send_beat(kps_pkg::CMD_READ_KEY, kps_pkg::MAP_W'($urandom));
		if ($urandom_range(3) != 0)
			send_beat(kps_pkg::CMD_READ_LONG, kps_pkg::MAP_W'($urandom));
		if ($urandom_range(7) == 0)
			send_beat(kps_pkg::CMD_READ_KEY, kps_pkg::MAP_W'($urandom));
	endtask

	task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
		input logic [kps_pkg::COUNT_W-1:0] limit);
		int unsigned start;
		write_threshold(limit);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		start = sent;
		while (sent - start < PHASE_ITEMS) begin
			if ($urandom_range(9) < 7)
				press_release();
			else
				repeat (3)
					send_beat(kps_pkg::CMD_W'($urandom_range(3)),
						kps_pkg::MAP_W'($urandom));
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_wr_en         = 1'b0;
		cfg_wr_data       = '0;
		scan_in.valid     = 1'b0;
		scan_in.cmd       = kps_pkg::CMD_TICK;
		scan_in.row1_cols = '0;
		scan_in.row2_cols = '0;
		scan_in.row3_cols = '0;
		scan_in.row4_cols = '0;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reads on empty state, unused command, all-keys and corner keys
		send_beat(kps_pkg::CMD_READ_KEY, 16'hFFFF);
		send_beat(kps_pkg::CMD_READ_LONG, 16'h0000);
		send_beat(CMD_UNUSED, 16'hFFFF);
		send_beat(kps_pkg::CMD_TICK, 16'hFFFF);
		send_beat(CMD_UNUSED, 16'h0000);
		send_beat(kps_pkg::CMD_TICK, 16'h0000);
		send_beat(kps_pkg::CMD_READ_KEY, 16'h0000);
		send_beat(kps_pkg::CMD_TICK, 16'h0001);
		send_beat(kps_pkg::CMD_TICK, 16'h8000);
		send_beat(kps_pkg::CMD_TICK, 16'h0000);
		send_beat(kps_pkg::CMD_TICK, 16'h0000);
		send_beat(kps_pkg::CMD_READ_KEY, 16'h0000);
		send_beat(kps_pkg::CMD_READ_KEY, 16'h0000);

		// default threshold: one tick over it, then exactly at it
		hold_map(16'h0020, 31);
		send_beat(kps_pkg::CMD_TICK, 16'h0000);
		send_beat(kps_pkg::CMD_READ_LONG, 16'h0000);
		hold_map(16'h0400, 30);
		send_beat(kps_pkg::CMD_TICK, 16'h0000);
		send_beat(kps_pkg::CMD_READ_LONG, 16'h0000);

		// a short press must not clear a pending long-press flag
		write_threshold(16'd3);
		hold_map(16'h1000, 6);
		send_beat(kps_pkg::CMD_TICK, 16'h0000);
		hold_map(16'h0002, 2);
		send_beat(kps_pkg::CMD_TICK, 16'h0000);
		send_beat(kps_pkg::CMD_READ_LONG, 16'h0000);
		send_beat(kps_pkg::CMD_READ_KEY, 16'h0000);

		// first random phase runs under a long result hold-off
		drain();
		fork
			begin
				hold_off <= 1'b1;
				repeat (HOLDOFF_CYCLES)
					@(posedge clk);
				hold_off <= 1'b0;
			end
		join_none
		run_phase(0, 0, 16'd5);
		run_phase(47, 0, 16'd0);
		run_phase(0, 47, 16'd3);
		run_phase(24, 24, kps_pkg::COUNT_W'($urandom_range(10, 1)));

		recv_stall_pct = 0;
		drain();
		repeat (8)
			@(posedge clk);

		$display("%0d beats sent, %0d results checked, %0d mismatches",
			sent, board.checked, board.mismatches);
		$display("reads: %0d single key, %0d multi-key, %0d long press",
			board.single_reads, board.multi_reads, board.long_hits);
		if (board.failures() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule

// ----- filelist.f -----
rtl/kps_pkg.sv
rtl/kps_in_if.sv
rtl/kps_out_if.sv
rtl/kps_state.sv
rtl/matrix_keypad_scanner_core.sv
bench/tb_matrix_keypad_scanner_core.sv
